// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the checker files.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define MST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("matrix stack check failed");

// Next-cycle implication
`define MST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("matrix stack check failed");

`endif

// File: rtl/core/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg
// Shared constants, codes and interface structs of the matrix stack.
// ----------------------------------------------------------------------------
`default_nettype none

package mst_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int FRAC_BITS   = 16;

  localparam int WORD_W  = 32;
  localparam int IDX_W   = $clog2(STACK_DEPTH);
  localparam int ADDR_W  = IDX_W + 4;
  localparam int LEVEL_W = 6;
  // shifted product plus three-term growth
  localparam int ACC_W   = 64 - FRAC_BITS + 2;

  localparam logic signed [WORD_W-1:0] FIX_ONE = 32'sd1 <<< FRAC_BITS;

  typedef enum logic [1:0] {
    FN_PUSH      = 2'd0,
    FN_POP       = 2'd1,
    FN_TRANSLATE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POP_BOTTOM = 2'd1,
    ST_PUSH_FULL  = 2'd2,
    ST_SATURATED  = 2'd3
  } status_t;

  // store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } store_wr_t;

  // word handed to the multiply-accumulate unit
  typedef struct packed {
    logic                     valid;
    logic [1:0]               k;
    logic [1:0]               row;
    logic signed [WORD_W-1:0] data;
  } mac_req_t;

  // finished column 3 element
  typedef struct packed {
    logic                     valid;
    logic [1:0]               row;
    logic signed [WORD_W-1:0] data;
    logic                     sat;
  } mac_res_t;

endpackage

`default_nettype wire

// File: rtl/core/mst_store.sv
// ----------------------------------------------------------------------------
// mst_store
// Matrix word memory, one write and one registered read per cycle. The
// bottom entry reads as identity until each of its words is written.
// ----------------------------------------------------------------------------
`default_nettype none

module mst_store (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mst_pkg::store_wr_t          wr,
  input  wire logic                        rd_en,
  input  wire logic [mst_pkg::ADDR_W-1:0]  rd_addr,
  output logic signed [mst_pkg::WORD_W-1:0] rd_data
);
  import mst_pkg::*;

  localparam int DEPTH = STACK_DEPTH * 16;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] mem_q_r;
  logic [15:0]       bot_vld_r;
  logic              use_ident_r;
  logic              ident_diag_r;

  logic              rd_bottom;
  logic [3:0]        rd_word;

  assign rd_word   = rd_addr[3:0];
  assign rd_bottom = (rd_addr[ADDR_W-1:4] == '0);

  // write memory
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read memory, note whether the word still holds its identity value
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r      <= mem[rd_addr];
      use_ident_r  <= rd_bottom && !bot_vld_r[rd_word];
      ident_diag_r <= (rd_word[3:2] == rd_word[1:0]);
    end
  end

  // track written words of the bottom entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bot_vld_r <= '0;
    end else if (wr.en && (wr.addr[ADDR_W-1:4] == '0)) begin
      bot_vld_r[wr.addr[3:0]] <= 1'b1;
    end
  end

  assign rd_data = use_ident_r ? (ident_diag_r ? FIX_ONE : '0) : $signed(mem_q_r);

endmodule

`default_nettype wire

// File: rtl/core/mst_mac.sv
// ----------------------------------------------------------------------------
// mst_mac
// Shared multiply-accumulate unit of translate: one 32x32 product per cycle,
// registered, then shift, accumulate and saturate per row.
// ----------------------------------------------------------------------------
`default_nettype none

module mst_mac (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire mst_pkg::mac_req_t                  req,
  input  wire logic signed [mst_pkg::WORD_W-1:0]  tx,
  input  wire logic signed [mst_pkg::WORD_W-1:0]  ty,
  input  wire logic signed [mst_pkg::WORD_W-1:0]  tz,
  output mst_pkg::mac_res_t                       res
);
  import mst_pkg::*;

  logic                     v1_r;
  logic [1:0]               k1_r;
  logic [1:0]               row1_r;
  logic signed [63:0]       prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [WORD_W-1:0] tsel;
  logic signed [63:0]       prod_nxt;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  sum;
  logic                     ovf;

  // pick the translation term for this column
  always_comb begin
    case (req.k)
      2'd0:    tsel = tx;
      2'd1:    tsel = ty;
      default: tsel = tz;
    endcase
    if (req.k == 2'd3) begin
      prod_nxt = 64'(req.data);
    end else begin
      prod_nxt = 64'(req.data) * 64'(tsel);
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      k1_r   <= req.k;
      row1_r <= req.row;
      prod_r <= prod_nxt;
    end
  end

  // shift and accumulate; column 3 element enters unshifted
  always_comb begin
    if (k1_r == 2'd3) begin
      term = ACC_W'(prod_r);
    end else begin
      term = ACC_W'(prod_r >>> FRAC_BITS);
    end
    sum = ((k1_r == 2'd0) ? '0 : acc_r) + term;
    ovf = !((&sum[ACC_W-1:WORD_W-1]) || !(|sum[ACC_W-1:WORD_W-1]));
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      acc_r <= sum;
    end
  end

  // saturate the finished row
  always_comb begin
    res.valid = v1_r && (k1_r == 2'd3);
    res.row   = row1_r;
    res.sat   = ovf;
    if (ovf) begin
      res.data = sum[ACC_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      res.data = sum[WORD_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/matrix_stack_translate.sv
// ----------------------------------------------------------------------------
// matrix_stack_translate
// Stack of 4x4 Q16.16 transform matrices with push, pop and translate.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays
// high until the command is done. Every command returns the top matrix as
// four column words, column 0 first, each shown for one cycle with out_valid
// and never stalled, so the receiver must take them as they come. The store
// has one read port, so each command reads the top matrix word by word:
// pop, an ignored push and an unused code make a readout pass, push a copy
// pass, then a readout pass, and translate a pass through the single 32x32
// multiplier, then a readout pass. No clearing pass after reset: the bottom
// entry reads as identity until written.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_stack_translate (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         in_func,
  input  wire logic signed [31:0]                 in_tx,
  input  wire logic signed [31:0]                 in_ty,
  input  wire logic signed [31:0]                 in_tz,
  output logic                                    out_valid,
  output logic [1:0]                              out_column,
  output logic signed [31:0]                      out_row0,
  output logic signed [31:0]                      out_row1,
  output logic signed [31:0]                      out_row2,
  output logic signed [31:0]                      out_row3,
  output logic [mst_pkg::LEVEL_W-1:0]             out_level,
  output logic [1:0]                              out_status,
  output logic                                    out_last
);
  import mst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_COPY = 4'b0010,
    S_MAC  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [4:0]               cnt_r, cnt_nxt;
  logic [IDX_W-1:0]         top_r, top_nxt;
  status_t                  status_r, status_nxt;
  logic                     sat_r, sat_nxt;
  logic                     rv_r;
  logic [3:0]               rword_r;
  logic signed [31:0]       tx_r, ty_r, tz_r;
  logic signed [31:0]       buf_r [3];

  logic                     out_valid_r;
  logic [1:0]               out_column_r;
  logic signed [31:0]       out_row_r [4];
  logic [LEVEL_W-1:0]       out_level_r;
  status_t                  out_status_r;

  logic                     accept;
  logic                     issue;
  logic [3:0]               word_sel;
  logic [IDX_W-1:0]         top_p1;
  logic                     can_push;
  logic [IDX_W:0]           level_full;
  logic                     emit;
  logic signed [31:0]       rd_data;
  store_wr_t                wr;
  mac_req_t                 mreq;
  mac_res_t                 mres;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign top_p1   = top_r + IDX_W'(1);
  assign can_push = (({1'b0, top_r} + (IDX_W+1)'(1)) < (IDX_W+1)'(STACK_DEPTH));
  assign issue    = !cnt_r[4] &&
                    ((state_r == S_COPY) || (state_r == S_MAC) || (state_r == S_OUT));
  // translate walks row by row, the other passes column by column
  assign word_sel = (state_r == S_MAC) ? {cnt_r[1:0], cnt_r[3:2]} : cnt_r[3:0];
  assign emit     = rv_r && (state_r == S_OUT) && (rword_r[1:0] == 2'd3);

  mst_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_en   (issue),
    .rd_addr ({top_r, word_sel}),
    .rd_data (rd_data)
  );

  assign mreq.valid = rv_r && (state_r == S_MAC);
  assign mreq.k     = rword_r[3:2];
  assign mreq.row   = rword_r[1:0];
  assign mreq.data  = rd_data;

  mst_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .tx    (tx_r),
    .ty    (ty_r),
    .tz    (tz_r),
    .res   (mres)
  );

  // store writes: copy pass or new column 3 element
  always_comb begin
    wr = '0;
    if (state_r == S_COPY) begin
      wr.en   = rv_r;
      wr.addr = {top_p1, rword_r};
      wr.data = rd_data;
    end else if (state_r == S_MAC) begin
      wr.en   = mres.valid;
      wr.addr = {top_r, 2'd3, mres.row};
      wr.data = mres.data;
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = issue ? cnt_r + 5'd1 : cnt_r;
    top_nxt    = top_r;
    status_nxt = status_r;
    sat_nxt    = sat_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt    = '0;
          sat_nxt    = 1'b0;
          status_nxt = ST_OK;
          state_nxt  = S_OUT;
          case (in_func)
            FN_PUSH: begin
              if (can_push) begin
                state_nxt = S_COPY;
              end else begin
                status_nxt = ST_PUSH_FULL;
              end
            end
            FN_POP: begin
              if (top_r != '0) begin
                top_nxt = top_r - IDX_W'(1);
              end else begin
                status_nxt = ST_POP_BOTTOM;
              end
            end
            FN_TRANSLATE: begin
              state_nxt = S_MAC;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_COPY: begin
        if (rv_r && (rword_r == 4'd15)) begin
          top_nxt   = top_p1;
          cnt_nxt   = '0;
          state_nxt = S_OUT;
        end
      end
      S_MAC: begin
        if (mres.valid) begin
          sat_nxt = sat_r || mres.sat;
          if (mres.row == 2'd3) begin
            status_nxt = (sat_r || mres.sat) ? ST_SATURATED : ST_OK;
            cnt_nxt    = '0;
            state_nxt  = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (emit && (rword_r[3:2] == 2'd3)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      top_r    <= '0;
      status_r <= ST_OK;
      sat_r    <= 1'b0;
      rv_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      top_r    <= top_nxt;
      status_r <= status_nxt;
      sat_r    <= sat_nxt;
      rv_r     <= issue;
    end
  end

  // hold the word index of the read in flight and the translation
  always_ff @(posedge clk) begin
    if (issue) begin
      rword_r <= word_sel;
    end
    if (accept) begin
      tx_r <= in_tx;
      ty_r <= in_ty;
      tz_r <= in_tz;
    end
  end

  // gather a column, emit it with its fourth row
  assign level_full = {1'b0, top_r} + (IDX_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rv_r && (state_r == S_OUT) && (rword_r[1:0] != 2'd3)) begin
      buf_r[rword_r[1:0]] <= rd_data;
    end
    if (emit) begin
      out_column_r <= rword_r[3:2];
      out_row_r[0] <= buf_r[0];
      out_row_r[1] <= buf_r[1];
      out_row_r[2] <= buf_r[2];
      out_row_r[3] <= rd_data;
      out_level_r  <= LEVEL_W'(level_full);
      out_status_r <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_column = out_column_r;
  assign out_row0   = out_row_r[0];
  assign out_row1   = out_row_r[1];
  assign out_row2   = out_row_r[2];
  assign out_row3   = out_row_r[3];
  assign out_level  = out_level_r;
  assign out_status = out_status_r;
  assign out_last   = (out_column_r == 2'd3);

endmodule

`default_nettype wire

// File: rtl/core/mst_checker.sv
// ----------------------------------------------------------------------------
// mst_checker
// Port-level checks of the matrix stack, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mst_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic                          out_valid,
  input  wire logic [1:0]                    out_column,
  input  wire logic [mst_pkg::LEVEL_W-1:0]   out_level,
  input  wire logic [1:0]                    out_status,
  input  wire logic                          out_last
);
  import mst_pkg::*;

  // an accepted command keeps the block busy
  `MST_ASSERT_NXT(a_busy_after_start, clk, rst_n, start && !busy, busy)
  // no word shows the cycle after a command is taken
  `MST_ASSERT_NXT(a_no_word_after_start, clk, rst_n, start && !busy, !out_valid)
  // words before the last belong to a command still in progress
  `MST_ASSERT_IMP(a_busy_mid_item, clk, rst_n, out_valid && !out_last, busy)
  // last word carries column 3
  `MST_ASSERT_IMP(a_last_col, clk, rst_n, out_valid && out_last, out_column == 2'd3)
  // ignored pop leaves the bottom entry alone on the stack
  `MST_ASSERT_IMP(a_pop_bottom_level, clk, rst_n,
    out_valid && (out_status == ST_POP_BOTTOM), out_level == LEVEL_W'(1))

endmodule

bind matrix_stack_translate mst_checker u_mst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_column (out_column),
  .out_level  (out_level),
  .out_status (out_status),
  .out_last   (out_last)
);

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the matrix stack: random and directed push, pop,
// translate and unused-code words are driven into the command port. A local
// copy of the stack predicts the four column words of every command, and
// each word seen on the output port is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import mst_pkg::*;

  localparam logic [1:0] FN_UNUSED    = 2'd3;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         TAIL_CYCLES  = 80;
  localparam int         RANDOM_TOTAL = 250;
  localparam int         MAX_REPORTS  = 10;
  localparam longint     SAT_HI       = 64'sd2147483647;
  localparam longint     SAT_LO       = -64'sd2147483648;

  // one command word as queued for the driver
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] tz;
    logic        drain;
  } stack_cmd_t;

  // one column of the top matrix as the block reports it
  typedef struct packed {
    logic [1:0]         column;
    logic [3:0][31:0]   rows;
    logic [LEVEL_W-1:0] level;
    status_t            status;
    logic               last;
  } column_word_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               in_func = FN_UNUSED;
  logic signed [31:0]       in_tx = '0;
  logic signed [31:0]       in_ty = '0;
  logic signed [31:0]       in_tz = '0;
  logic                     out_valid;
  logic [1:0]               out_column;
  logic signed [31:0]       out_row0;
  logic signed [31:0]       out_row1;
  logic signed [31:0]       out_row2;
  logic signed [31:0]       out_row3;
  logic [LEVEL_W-1:0]       out_level;
  logic [1:0]               out_status;
  logic                     out_last;

  // predicted stack contents
  logic signed [31:0]       mat_stack [STACK_DEPTH][16];
  int unsigned              top_idx;

  stack_cmd_t               pending_cmds [$];
  column_word_t             columns_due [$];
  stack_cmd_t               cur_cmd;
  bit                       have_cmd = 1'b0;
  bit                       word_taken = 1'b0;
  bit                       drain_next = 1'b0;
  bit                       go;
  int                       gap_left = 0;
  int                       n_sent = 0;
  int                       idle_pct;
  int                       mismatches = 0;
  int                       cycle_count = 0;
  int                       settle_count = 0;

  matrix_stack_translate uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_func    (in_func),
    .in_tx      (in_tx),
    .in_ty      (in_ty),
    .in_tz      (in_tz),
    .out_valid  (out_valid),
    .out_column (out_column),
    .out_row0   (out_row0),
    .out_row1   (out_row1),
    .out_row2   (out_row2),
    .out_row3   (out_row3),
    .out_level  (out_level),
    .out_status (out_status),
    .out_last   (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one command to the local stack and queue its four column words.
  task automatic apply_matrix_op(input logic [1:0] fn, input logic signed [31:0] tx,
                                 input logic signed [31:0] ty,
                                 input logic signed [31:0] tz);
    status_t            st;
    logic signed [31:0] tv [3];
    longint             acc;
    longint             prod;
    bit                 clipped;
    column_word_t       w;
    st = ST_OK;
    clipped = 1'b0;
    tv[0] = tx;
    tv[1] = ty;
    tv[2] = tz;
    case (fn)
      FN_PUSH: begin
        if (top_idx + 1 < STACK_DEPTH) begin
          for (int i = 0; i < 16; i++) mat_stack[top_idx + 1][i] = mat_stack[top_idx][i];
          top_idx++;
        end else begin
          st = ST_PUSH_FULL;
        end
      end
      FN_POP: begin
        if (top_idx > 0) top_idx--;
        else st = ST_POP_BOTTOM;
      end
      FN_TRANSLATE: begin
        // new column 3 = c0*tx + c1*ty + c2*tz + c3, saturated once per row
        for (int r = 0; r < 4; r++) begin
          acc = longint'(mat_stack[top_idx][12 + r]);
          for (int k = 0; k < 3; k++) begin
            prod = longint'(mat_stack[top_idx][k * 4 + r]) * longint'(tv[k]);
            acc += prod >>> FRAC_BITS;
          end
          if (acc > SAT_HI) begin
            acc = SAT_HI;
            clipped = 1'b1;
          end else if (acc < SAT_LO) begin
            acc = SAT_LO;
            clipped = 1'b1;
          end
          mat_stack[top_idx][12 + r] = acc[31:0];
        end
        if (clipped) st = ST_SATURATED;
      end
      default: ;
    endcase
    for (int c = 0; c < 4; c++) begin
      w.column = c[1:0];
      for (int r = 0; r < 4; r++) w.rows[r] = mat_stack[top_idx][c * 4 + r];
      w.level  = LEVEL_W'(top_idx + 1);
      w.status = st;
      w.last   = (c == 3);
      columns_due.push_back(w);
    end
  endtask

  // Compare the word on the output port with the oldest prediction.
  task automatic check_column_word();
    column_word_t got;
    column_word_t want;
    got.column = out_column;
    got.rows   = {out_row3, out_row2, out_row1, out_row0};
    got.level  = out_level;
    got.status = status_t'(out_status);
    got.last   = out_last;
    if (columns_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected column word: col %0d rows %h %h %h %h level %0d status %0d",
                 got.column, got.rows[0], got.rows[1], got.rows[2], got.rows[3],
                 got.level, got.status);
    end else begin
      want = columns_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("column word mismatch, expected: col %0d rows %h %h %h %h lvl %0d st %0d last %0d",
                   want.column, want.rows[0], want.rows[1], want.rows[2], want.rows[3],
                   want.level, want.status, want.last);
          $display("                          got: col %0d rows %h %h %h %h lvl %0d st %0d last %0d",
                   got.column, got.rows[0], got.rows[1], got.rows[2], got.rows[3],
                   got.level, got.status, got.last);
        end
      end
    end
  endtask

  task automatic add_cmd(input logic [1:0] fn, input logic [31:0] tx, input logic [31:0] ty,
                         input logic [31:0] tz);
    stack_cmd_t c;
    c.func  = fn;
    c.tx    = tx;
    c.ty    = ty;
    c.tz    = tz;
    c.drain = drain_next;
    drain_next = 1'b0;
    pending_cmds.push_back(c);
  endtask

  // Translation value: full range, small signed, extremes or fraction only.
  function automatic logic [31:0] pick_offset();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0, 1:    v = $urandom;
      2, 3:    v = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      4: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0000;
        endcase
      end
      default: v = {{16{$urandom_range(0, 1) == 1}}, 16'($urandom_range(0, 16'hFFFF))};
    endcase
    return v;
  endfunction

  // Fill the command queue, then release reset.
  initial begin
    int          seg;
    int          len;
    int          pick;
    logic [1:0]  fn;
    for (int e = 0; e < STACK_DEPTH; e++)
      for (int i = 0; i < 16; i++) mat_stack[e][i] = '0;
    for (int i = 0; i < 4; i++) mat_stack[0][i * 4 + i] = FIX_ONE;
    top_idx = 0;

    // directed: reset readout, bottom pop, translates to both rails, nesting
    add_cmd(FN_UNUSED, 32'h0, 32'h0, 32'h0);
    add_cmd(FN_POP, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    add_cmd(FN_TRANSLATE, 32'h0001_0000, 32'h0002_0000, 32'hFFFC_8000);
    add_cmd(FN_TRANSLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_cmd(FN_PUSH, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_cmd(FN_TRANSLATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_cmd(FN_TRANSLATE, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0001);
    add_cmd(FN_PUSH, 32'h0, 32'h0, 32'h0);
    add_cmd(FN_TRANSLATE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_cmd(FN_TRANSLATE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_cmd(FN_UNUSED, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_AAAA);
    add_cmd(FN_POP, 32'h0, 32'h0, 32'h0);
    add_cmd(FN_TRANSLATE, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001);
    add_cmd(FN_POP, 32'h0, 32'h0, 32'h0);
    add_cmd(FN_POP, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
    add_cmd(FN_TRANSLATE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    add_cmd(FN_PUSH, 32'hAAAA_5555, 32'h0, 32'hFFFF_FFFF);
    add_cmd(FN_TRANSLATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    add_cmd(FN_POP, 32'h0, 32'h0, 32'h0);
    add_cmd(FN_UNUSED, 32'h0, 32'h0, 32'h0);

    // fill the stack past full, then random segments
    drain_next = 1'b1;
    repeat (STACK_DEPTH + 2) add_cmd(FN_PUSH, pick_offset(), pick_offset(), pick_offset());
    while (pending_cmds.size() < RANDOM_TOTAL) begin
      seg = $urandom_range(0, 9);
      if (seg <= 1) begin
        len = $urandom_range(1, STACK_DEPTH + 2);
        repeat (len) add_cmd(FN_PUSH, pick_offset(), pick_offset(), pick_offset());
      end else if (seg <= 3) begin
        len = $urandom_range(1, STACK_DEPTH + 2);
        repeat (len) add_cmd(FN_POP, pick_offset(), pick_offset(), pick_offset());
      end else if (seg <= 7) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          pick = $urandom_range(0, 19);
          if (pick < 12)      fn = FN_TRANSLATE;
          else if (pick < 15) fn = FN_PUSH;
          else if (pick < 18) fn = FN_POP;
          else                fn = FN_UNUSED;
          add_cmd(fn, pick_offset(), pick_offset(), pick_offset());
        end
      end else if (seg == 8) begin
        add_cmd(FN_UNUSED, pick_offset(), pick_offset(), pick_offset());
      end else begin
        drain_next = 1'b1;
      end
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
  end

  // Driver: take the next word, idle for its gap, hold start until taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (have_cmd && start && word_taken) have_cmd = 1'b0;
      if (!have_cmd && pending_cmds.size() > 0) begin
        cur_cmd  = pending_cmds.pop_front();
        have_cmd = 1'b1;
        idle_pct = (n_sent < RANDOM_TOTAL / 3) ? 22 : (n_sent < 2 * RANDOM_TOTAL / 3) ? 45 : 0;
        gap_left = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 45) : 0;
        // phase boundaries wait for the block to drain
        if (n_sent == RANDOM_TOTAL / 3 || n_sent == 2 * RANDOM_TOTAL / 3) cur_cmd.drain = 1'b1;
        n_sent++;
      end
      go = 1'b0;
      if (have_cmd) begin
        if (start && !word_taken) go = 1'b1;
        else if (cur_cmd.drain && columns_due.size() != 0) go = 1'b0;
        else if (gap_left > 0) gap_left--;
        else go = 1'b1;
      end
      start <= go;
      if (go) begin
        in_func <= cur_cmd.func;
        in_tx   <= cur_cmd.tx;
        in_ty   <= cur_cmd.ty;
        in_tz   <= cur_cmd.tz;
      end
    end
  end

  // Monitor: check output words, predict taken commands, decide the end.
  always @(posedge clk) begin
    cycle_count++;
    word_taken = rst_n && start && !busy;
    if (rst_n && out_valid) check_column_word();
    if (word_taken) apply_matrix_op(in_func, in_tx, in_ty, in_tz);
    if (rst_n && pending_cmds.size() == 0 && !have_cmd && columns_due.size() == 0)
      settle_count++;
    else
      settle_count = 0;
    if (settle_count >= TAIL_CYCLES) begin
      if (mismatches == 0) begin
        $display("CHECK OK");
      end else begin
        $display("CHECK FAILED");
      end
      $finish;
    end else if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

`default_nettype wire
